[hw/rtl/selective_repeat_arq_engine_top_assert.svh]
// Assertion macros shared by the ARQ engine RTL.
`ifndef SELECTIVE_REPEAT_ARQ_ENGINE_TOP_ASSERT_SVH
`define SELECTIVE_REPEAT_ARQ_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRA_ASSERT_NEVER(lbl, expr, msg) `SRA_ASSERT(lbl, !(expr), msg)
`else
`define SRA_ASSERT(lbl, prop, msg)
`define SRA_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

[hw/rtl/sra_pkg.sv]
// Types, constants and helper functions of the selective-repeat ARQ engine.
`timescale 1ns / 1ps
package sra_pkg;
    localparam int MAX_SEQ_NUM = 7;
    localparam int SEQ_MOD = MAX_SEQ_NUM + 1;
    localparam int NR_SLOTS = SEQ_MOD / 2;
    localparam int SEQ_W = 3;
    localparam int SLOT_W = 2;
    localparam int CNT_W = 3;
    localparam int CFG_W = 16;
    localparam int TIMER_BITS_DEF = 16;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd5;

    localparam logic [1:0] MODE_NET_READY = 2'd0;
    localparam logic [1:0] MODE_ARRIVAL = 2'd1;
    localparam logic [1:0] MODE_CKSUM_ERR = 2'd2;
    localparam logic [1:0] MODE_TICK = 2'd3;

    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_ACK = 2'd1;
    localparam logic [1:0] FRAME_NAK = 2'd2;
    localparam logic [1:0] FRAME_BAD = 2'd3;

    localparam logic [1:0] OUT_STATUS = 2'd0;
    localparam logic [1:0] OUT_TRANSMIT = 2'd1;
    localparam logic [1:0] OUT_STORE = 2'd2;
    localparam logic [1:0] OUT_DELIVER = 2'd3;

    typedef struct packed {
        logic [1:0]       mode;
        logic [1:0]       rx_kind;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] frame_ack;
    } sra_in_t;

    typedef struct packed {
        logic [1:0]        out_kind;
        logic [1:0]        tx_kind;
        logic [SEQ_W-1:0]  tx_seq;
        logic [SEQ_W-1:0]  tx_ack;
        logic [SLOT_W-1:0] slot;
        logic              net_enable;
        logic              last;
    } sra_out_t;

    function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
        logic [SEQ_W-1:0] r;
        if (s == '0)
        begin
            r = SEQ_W'(MAX_SEQ_NUM);
        end
        else
        begin
            r = s - 1'b1;
        end
        return r;
    endfunction
endpackage

[hw/rtl/sra_seq_unit.sv]
// Shared sequence unit: circular window test and two modular increments.
`timescale 1ns / 1ps
module sra_seq_unit
    import sra_pkg::*;
(
    input  logic [SEQ_W-1:0] a,
    input  logic [SEQ_W-1:0] b,
    input  logic [SEQ_W-1:0] c,
    input  logic [SEQ_W-1:0] x,
    input  logic [SEQ_W-1:0] y,
    output logic             in_window,
    output logic [SEQ_W-1:0] x_inc,
    output logic [SEQ_W-1:0] y_inc
);
    assign in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b))
                       || ((b < c) && (c < a));
    assign x_inc = (x == SEQ_W'(MAX_SEQ_NUM)) ? '0 : x + 1'b1;
    assign y_inc = (y == SEQ_W'(MAX_SEQ_NUM)) ? '0 : y + 1'b1;
endmodule

[hw/rtl/selective_repeat_arq_engine_top.sv]
// Each transaction ends with its status result; at most one result per cycle.
// One transaction at a time; the next start is taken once busy falls.
// A tick advances the timers, then checks each slot and the ack timer; an arrival runs the
// NAK, store, per-payload delivery, resend and per-acked-frame ack states before status.
// Reset at once zeroes timers, arrival map and window edges bar the upper (4); timeout is 5.
// Results are strobed for one cycle each; the receiver cannot stall them.
`timescale 1ns / 1ps
module selective_repeat_arq_engine_top
    import sra_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sra_in_t  req,
    output logic     result_valid,
    output sra_out_t result,
    input  logic     cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);
`include "selective_repeat_arq_engine_top_assert.svh"

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_SEND, S_CKERR, S_TICK_ADV, S_TICK_SLOT, S_TICK_ACK,
        S_ARR_NAK, S_ARR_STORE, S_ARR_DELIV, S_ARR_RESEND, S_ARR_ACK, S_STATUS
    } state_t;

    state_t state_reg, state_next;
    sra_in_t in_reg, in_next;
    logic [CFG_W-1:0] timeout_reg, timeout_next;
    logic [SEQ_W-1:0] aes_reg, aes_next, nss_reg, nss_next;
    logic [SEQ_W-1:0] es_reg, es_next, wu_reg, wu_next;
    logic [CNT_W-1:0] oc_reg, oc_next;
    logic nak_ok_reg, nak_ok_next;
    logic [NR_SLOTS-1:0] arr_reg, arr_next;
    logic [SEQ_W-1:0] slot_seq_reg [NR_SLOTS];
    logic [NR_SLOTS-1:0] srun_reg, srun_next;
    logic [TIMER_BITS-1:0] scnt_reg [NR_SLOTS];
    logic [TIMER_BITS-1:0] scnt_next [NR_SLOTS];
    logic arun_reg, arun_next;
    logic [TIMER_BITS-1:0] acnt_reg, acnt_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic valid_reg, valid_next;
    sra_out_t res_reg, res_next;
    logic ss_we;
    logic [SLOT_W-1:0] ss_addr;

    logic [SEQ_W-1:0] ua, ub, uc, ux, uy, ux_inc, uy_inc;
    logic u_win;

    sra_seq_unit u_seq (
        .a(ua), .b(ub), .c(uc), .x(ux), .y(uy),
        .in_window(u_win), .x_inc(ux_inc), .y_inc(uy_inc)
    );

    always_comb
    begin
        ua = aes_reg;
        ub = in_reg.frame_ack;
        uc = nss_reg;
        ux = nss_reg;
        uy = wu_reg;
        unique case (state_reg)
            S_ARR_STORE:
            begin
                ua = es_reg;
                ub = in_reg.frame_seq;
                uc = wu_reg;
            end
            S_ARR_DELIV:
            begin
                ux = es_reg;
            end
            S_ARR_RESEND:
            begin
                ux = in_reg.frame_ack;
                ub = ux_inc;
            end
            S_ARR_ACK:
            begin
                ux = aes_reg;
            end
            default:
            begin
            end
        endcase
    end

    function automatic logic expired(input logic run, input logic [TIMER_BITS-1:0] cnt,
                                     input logic [CFG_W-1:0] lim);
        return run && (CMP_W'(cnt) >= CMP_W'(lim));
    endfunction

    always_comb
    begin
        logic [SLOT_W-1:0] s;
        state_next = state_reg;
        in_next = in_reg;
        timeout_next = cfg_we ? cfg_data : timeout_reg;
        aes_next = aes_reg;
        nss_next = nss_reg;
        es_next = es_reg;
        wu_next = wu_reg;
        oc_next = oc_reg;
        nak_ok_next = nak_ok_reg;
        arr_next = arr_reg;
        srun_next = srun_reg;
        scnt_next = scnt_reg;
        arun_next = arun_reg;
        acnt_next = acnt_reg;
        idx_next = idx_reg;
        valid_next = 1'b0;
        res_next = '0;
        res_next.tx_ack = seq_prev(es_reg);
        ss_we = 1'b0;
        ss_addr = nss_reg[SLOT_W-1:0];
        s = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next = req;
                    if (req.rx_kind == FRAME_BAD)
                    begin
                        in_next.rx_kind = FRAME_ACK;
                    end
                    unique case (req.mode)
                        MODE_NET_READY: state_next = S_SEND;
                        MODE_ARRIVAL: state_next = S_ARR_NAK;
                        MODE_CKSUM_ERR: state_next = S_CKERR;
                        MODE_TICK: state_next = S_TICK_ADV;
                    endcase
                end
            end
            S_SEND:
            begin
                if (oc_reg < CNT_W'(NR_SLOTS))
                begin
                    s = nss_reg[SLOT_W-1:0];
                    oc_next = oc_reg + 1'b1;
                    ss_we = 1'b1;
                    valid_next = 1'b1;
                    res_next.out_kind = OUT_TRANSMIT;
                    res_next.tx_kind = FRAME_DATA;
                    res_next.tx_seq = nss_reg;
                    res_next.slot = s;
                    srun_next[s] = 1'b1;
                    scnt_next[s] = '0;
                    arun_next = 1'b0;
                    acnt_next = '0;
                    nss_next = ux_inc;
                end
                state_next = S_STATUS;
            end
            S_CKERR:
            begin
                if (nak_ok_reg)
                begin
                    valid_next = 1'b1;
                    res_next.out_kind = OUT_TRANSMIT;
                    res_next.tx_kind = FRAME_NAK;
                    nak_ok_next = 1'b0;
                    arun_next = 1'b0;
                    acnt_next = '0;
                end
                state_next = S_STATUS;
            end
            S_TICK_ADV:
            begin
                for (int i = 0; i < NR_SLOTS; i++)
                begin
                    if (srun_reg[i] && scnt_reg[i] != TMAX)
                    begin
                        scnt_next[i] = scnt_reg[i] + 1'b1;
                    end
                end
                if (arun_reg && acnt_reg != TMAX)
                begin
                    acnt_next = acnt_reg + 1'b1;
                end
                idx_next = '0;
                state_next = S_TICK_SLOT;
            end
            S_TICK_SLOT:
            begin
                if (expired(srun_reg[idx_reg], scnt_reg[idx_reg], timeout_reg))
                begin
                    valid_next = 1'b1;
                    res_next.out_kind = OUT_TRANSMIT;
                    res_next.tx_kind = FRAME_DATA;
                    res_next.tx_seq = slot_seq_reg[idx_reg];
                    res_next.slot = idx_reg;
                    scnt_next[idx_reg] = '0;
                    arun_next = 1'b0;
                    acnt_next = '0;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == SLOT_W'(NR_SLOTS - 1))
                begin
                    state_next = S_TICK_ACK;
                end
            end
            S_TICK_ACK:
            begin
                if (expired(arun_reg, acnt_reg, timeout_reg))
                begin
                    valid_next = 1'b1;
                    res_next.out_kind = OUT_TRANSMIT;
                    res_next.tx_kind = FRAME_ACK;
                    arun_next = 1'b0;
                    acnt_next = '0;
                end
                state_next = S_STATUS;
            end
            S_ARR_NAK:
            begin
                if (in_reg.rx_kind == FRAME_DATA)
                begin
                    if (in_reg.frame_seq != es_reg && nak_ok_reg)
                    begin
                        valid_next = 1'b1;
                        res_next.out_kind = OUT_TRANSMIT;
                        res_next.tx_kind = FRAME_NAK;
                        nak_ok_next = 1'b0;
                        arun_next = 1'b0;
                    end
                    else
                    begin
                        arun_next = 1'b1;
                    end
                    acnt_next = '0;
                end
                state_next = S_ARR_STORE;
            end
            S_ARR_STORE:
            begin
                s = in_reg.frame_seq[SLOT_W-1:0];
                state_next = S_ARR_RESEND;
                if (in_reg.rx_kind == FRAME_DATA && u_win && !arr_reg[s])
                begin
                    arr_next[s] = 1'b1;
                    valid_next = 1'b1;
                    res_next = '0;
                    res_next.out_kind = OUT_STORE;
                    res_next.slot = s;
                    state_next = S_ARR_DELIV;
                end
            end
            S_ARR_DELIV:
            begin
                s = es_reg[SLOT_W-1:0];
                if (arr_reg[s])
                begin
                    valid_next = 1'b1;
                    res_next = '0;
                    res_next.out_kind = OUT_DELIVER;
                    res_next.slot = s;
                    nak_ok_next = 1'b1;
                    arr_next[s] = 1'b0;
                    es_next = ux_inc;
                    wu_next = uy_inc;
                    arun_next = 1'b1;
                    acnt_next = '0;
                end
                else
                begin
                    state_next = S_ARR_RESEND;
                end
            end
            S_ARR_RESEND:
            begin
                s = ux_inc[SLOT_W-1:0];
                if (in_reg.rx_kind == FRAME_NAK && u_win)
                begin
                    valid_next = 1'b1;
                    res_next.out_kind = OUT_TRANSMIT;
                    res_next.tx_kind = FRAME_DATA;
                    res_next.tx_seq = ux_inc;
                    res_next.slot = s;
                    srun_next[s] = 1'b1;
                    scnt_next[s] = '0;
                    arun_next = 1'b0;
                    acnt_next = '0;
                end
                state_next = S_ARR_ACK;
            end
            S_ARR_ACK:
            begin
                s = aes_reg[SLOT_W-1:0];
                if (u_win)
                begin
                    if (oc_reg != '0)
                    begin
                        oc_next = oc_reg - 1'b1;
                    end
                    srun_next[s] = 1'b0;
                    scnt_next[s] = '0;
                    aes_next = ux_inc;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                valid_next = 1'b1;
                res_next = '0;
                res_next.out_kind = OUT_STATUS;
                res_next.net_enable = (oc_reg < CNT_W'(NR_SLOTS));
                res_next.last = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            aes_reg <= '0;
            nss_reg <= '0;
            es_reg <= '0;
            wu_reg <= SEQ_W'(NR_SLOTS);
            oc_reg <= '0;
            nak_ok_reg <= 1'b1;
            arr_reg <= '0;
            srun_reg <= '0;
            for (int i = 0; i < NR_SLOTS; i++)
            begin
                scnt_reg[i] <= '0;
            end
            arun_reg <= 1'b0;
            acnt_reg <= '0;
            idx_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            timeout_reg <= timeout_next;
            aes_reg <= aes_next;
            nss_reg <= nss_next;
            es_reg <= es_next;
            wu_reg <= wu_next;
            oc_reg <= oc_next;
            nak_ok_reg <= nak_ok_next;
            arr_reg <= arr_next;
            srun_reg <= srun_next;
            scnt_reg <= scnt_next;
            arun_reg <= arun_next;
            acnt_reg <= acnt_next;
            idx_reg <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
        res_reg <= res_next;
        if (ss_we)
        begin
            slot_seq_reg[ss_addr] <= nss_reg;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = valid_reg;
    assign result = res_reg;

    `SRA_ASSERT(a_last_idle, (result_valid && result.last) |-> !busy, "status not at end")
    `SRA_ASSERT(a_start_busy, (start && !busy) |=> busy, "start not taken")
    `SRA_ASSERT_NEVER(a_oc_range, oc_reg > CNT_W'(NR_SLOTS), "outstanding count overflow")
    `SRA_ASSERT(a_window, SEQ_W'(wu_reg - es_reg) == SEQ_W'(NR_SLOTS), "window edges apart")
endmodule

[tb/testbench.sv]
// Self-checking testbench for the selective-repeat ARQ engine with its own transaction predictor.
`timescale 1ns / 1ps
module testbench;
    import sra_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMER_MAX = 65535;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    sra_in_t req;
    logic result_valid;
    sra_out_t result;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_data;

    selective_repeat_arq_engine_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req(req),
        .result_valid(result_valid),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    sra_out_t expected_results[$];
    int mismatches;
    int cycle_count;
    bit steady_sender;

    logic [SEQ_W-1:0] ack_edge;
    logic [SEQ_W-1:0] next_to_send;
    logic [SEQ_W-1:0] recv_edge;
    logic [SEQ_W-1:0] window_upper;
    int unsigned outstanding;
    bit nak_allowed;
    bit arrived[NR_SLOTS];
    logic [SEQ_W-1:0] slot_seq[NR_SLOTS];
    bit slot_running[NR_SLOTS];
    int unsigned slot_count[NR_SLOTS];
    bit ack_running;
    int unsigned ack_count;
    int unsigned timeout_ticks;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("selective_repeat_arq_engine_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sra_out_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %p", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.out_kind !== want.out_kind || result.tx_kind !== want.tx_kind ||
                    result.tx_seq !== want.tx_seq || result.tx_ack !== want.tx_ack ||
                    result.slot !== want.slot || result.net_enable !== want.net_enable ||
                    result.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    function automatic bit seq_between(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [1:0] txk,
                               input logic [SEQ_W-1:0] sq, input logic [SEQ_W-1:0] ak,
                               input logic [SLOT_W-1:0] sl, input logic en, input logic lst);
        sra_out_t r;
        r.out_kind = kind;
        r.tx_kind = txk;
        r.tx_seq = sq;
        r.tx_ack = ak;
        r.slot = sl;
        r.net_enable = en;
        r.last = lst;
        expected_results.push_back(r);
    endtask

    task automatic tx_data_frame(input logic [SEQ_W-1:0] sq, input logic [SLOT_W-1:0] sl);
        push_result(OUT_TRANSMIT, FRAME_DATA, sq, recv_edge - 1'b1, sl, 1'b0, 1'b0);
        slot_running[sl] = 1'b1;
        slot_count[sl] = 0;
        ack_running = 1'b0;
        ack_count = 0;
    endtask

    task automatic tx_control_frame(input logic [1:0] kind);
        push_result(OUT_TRANSMIT, kind, '0, recv_edge - 1'b1, '0, 1'b0, 1'b0);
        if (kind == FRAME_NAK)
            nak_allowed = 1'b0;
        ack_running = 1'b0;
        ack_count = 0;
    endtask

    task automatic predict_transaction(input sra_in_t item);
        logic [1:0] kind;
        logic [SEQ_W-1:0] resend;
        logic [SLOT_W-1:0] sl;
        kind = (item.rx_kind == FRAME_BAD) ? FRAME_ACK : item.rx_kind;
        if (item.mode == MODE_NET_READY)
        begin
            if (outstanding < NR_SLOTS)
            begin
                sl = next_to_send[SLOT_W-1:0];
                outstanding++;
                slot_seq[sl] = next_to_send;
                tx_data_frame(next_to_send, sl);
                next_to_send = next_to_send + 1'b1;
            end
        end
        else if (item.mode == MODE_ARRIVAL)
        begin
            if (kind == FRAME_DATA)
            begin
                if (item.frame_seq != recv_edge && nak_allowed)
                    tx_control_frame(FRAME_NAK);
                else
                begin
                    ack_running = 1'b1;
                    ack_count = 0;
                end
                if (seq_between(recv_edge, item.frame_seq, window_upper) &&
                    !arrived[item.frame_seq[SLOT_W-1:0]])
                begin
                    arrived[item.frame_seq[SLOT_W-1:0]] = 1'b1;
                    push_result(OUT_STORE, '0, '0, '0, item.frame_seq[SLOT_W-1:0], 1'b0, 1'b0);
                    while (arrived[recv_edge[SLOT_W-1:0]])
                    begin
                        push_result(OUT_DELIVER, '0, '0, '0, recv_edge[SLOT_W-1:0],
                                    1'b0, 1'b0);
                        nak_allowed = 1'b1;
                        arrived[recv_edge[SLOT_W-1:0]] = 1'b0;
                        recv_edge = recv_edge + 1'b1;
                        window_upper = window_upper + 1'b1;
                        ack_running = 1'b1;
                        ack_count = 0;
                    end
                end
            end
            resend = item.frame_ack + 1'b1;
            if (kind == FRAME_NAK && seq_between(ack_edge, resend, next_to_send))
                tx_data_frame(resend, resend[SLOT_W-1:0]);
            while (seq_between(ack_edge, item.frame_ack, next_to_send))
            begin
                if (outstanding > 0)
                    outstanding--;
                slot_running[ack_edge[SLOT_W-1:0]] = 1'b0;
                slot_count[ack_edge[SLOT_W-1:0]] = 0;
                ack_edge = ack_edge + 1'b1;
            end
        end
        else if (item.mode == MODE_CKSUM_ERR)
        begin
            if (nak_allowed)
                tx_control_frame(FRAME_NAK);
        end
        else
        begin
            for (int i = 0; i < NR_SLOTS; i++)
                if (slot_running[i] && slot_count[i] < TIMER_MAX)
                    slot_count[i]++;
            if (ack_running && ack_count < TIMER_MAX)
                ack_count++;
            for (int i = 0; i < NR_SLOTS; i++)
                if (slot_running[i] && slot_count[i] >= timeout_ticks)
                    tx_data_frame(slot_seq[i], SLOT_W'(i));
            if (ack_running && ack_count >= timeout_ticks)
                tx_control_frame(FRAME_ACK);
        end
        push_result(OUT_STATUS, '0, '0, '0, '0, outstanding < NR_SLOTS, 1'b1);
    endtask

    task automatic send_transaction(input logic [1:0] mode, input logic [1:0] kind,
                                    input logic [SEQ_W-1:0] sq, input logic [SEQ_W-1:0] ak);
        sra_in_t item;
        item.mode = mode;
        item.rx_kind = kind;
        item.frame_seq = sq;
        item.frame_ack = ak;
        @(posedge clk);
        if (!steady_sender && $urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 8)) @(posedge clk);
        req <= item;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_transaction(item);
        start <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [CFG_W-1:0] value);
        wait_until_drained();
        cfg_data <= value;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_ticks = 32'(value);
    endtask

    task automatic test_directed();
        for (int i = 0; i < 5; i++)
            send_transaction(MODE_NET_READY, FRAME_DATA, '0, '0);
        send_transaction(MODE_ARRIVAL, FRAME_DATA, 3'd7, 3'd7);
        send_transaction(MODE_ARRIVAL, FRAME_DATA, 3'd1, 3'd7);
        send_transaction(MODE_ARRIVAL, FRAME_DATA, 3'd0, 3'd7);
        send_transaction(MODE_ARRIVAL, FRAME_NAK, 3'd0, 3'd0);
        send_transaction(MODE_ARRIVAL, FRAME_ACK, 3'd7, 3'd1);
        send_transaction(MODE_ARRIVAL, FRAME_BAD, 3'd0, 3'd2);
        send_transaction(MODE_CKSUM_ERR, FRAME_DATA, '0, '0);
        send_transaction(MODE_CKSUM_ERR, FRAME_DATA, '0, '0);
        for (int i = 0; i < 6; i++)
            send_transaction(MODE_TICK, FRAME_DATA, '0, '0);
        send_transaction(MODE_ARRIVAL, FRAME_ACK, 3'd0, 3'd3);
        send_transaction(MODE_ARRIVAL, FRAME_DATA, 3'd2, 3'd3);
        send_transaction(MODE_TICK, FRAME_DATA, 3'd7, 3'd7);
    endtask

    task automatic test_random(input int count);
        logic [1:0] mode;
        logic [1:0] kind;
        logic [SEQ_W-1:0] sq;
        logic [SEQ_W-1:0] ak;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            steady_sender = (n >= count / 3) && (n < count / 2);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                mode = MODE_NET_READY;
            else if (pick < 65)
                mode = MODE_ARRIVAL;
            else if (pick < 72)
                mode = MODE_CKSUM_ERR;
            else
                mode = MODE_TICK;
            pick = $urandom_range(0, 99);
            kind = (pick < 50) ? FRAME_DATA : (pick < 75) ? FRAME_ACK :
                   (pick < 92) ? FRAME_NAK : FRAME_BAD;
            if ($urandom_range(0, 9) < 8)
                sq = recv_edge + SEQ_W'($urandom_range(0, 4));
            else
                sq = SEQ_W'($urandom_range(0, 7));
            if ($urandom_range(0, 9) < 8)
                ak = ack_edge + SEQ_W'($urandom_range(0, 4)) - 1'b1;
            else
                ak = SEQ_W'($urandom_range(0, 7));
            send_transaction(mode, kind, sq, ak);
            if (n == count / 2)
                wait_until_drained();
        end
        steady_sender = 1'b0;
    endtask

    task automatic test_timeout_settings();
        write_timeout(16'd1);
        test_random(60);
        write_timeout(16'hFFFF);
        test_random(30);
        write_timeout(16'd2);
        test_random(60);
        write_timeout(CFG_W'($urandom_range(3, 9)));
        test_random(80);
        write_timeout(TIMEOUT_RESET);
        test_random(100);
    endtask

    initial
    begin
        steady_sender = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        ack_edge = '0;
        next_to_send = '0;
        recv_edge = '0;
        window_upper = SEQ_W'(NR_SLOTS);
        outstanding = 0;
        nak_allowed = 1'b1;
        ack_running = 1'b0;
        ack_count = 0;
        timeout_ticks = 32'(TIMEOUT_RESET);
        for (int i = 0; i < NR_SLOTS; i++)
        begin
            arrived[i] = 1'b0;
            slot_seq[i] = '0;
            slot_running[i] = 1'b0;
            slot_count[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_timeout_settings();
        wait_until_drained();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("selective_repeat_arq_engine_top verification clean");
        else
            $display("selective_repeat_arq_engine_top verification failed");
        $finish;
    end
endmodule
